// ===== design/psfc_pkg.sv =====
`timescale 1ns / 1ps

package psfc_pkg;

  // width of the wrapping tick counter and of the time stamps
  localparam int TIME_BITS = 8;
  localparam int CFG_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;
  // compare width for elapsed time against an 8-bit register
  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLAG_HOLD_TICKS = 2'd1;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_TICKS_RESET = 8'd3;
  localparam logic [CFG_BITS-1:0] FLAG_HOLD_TICKS_RESET = 8'd2;

  localparam logic [1:0] LED_OFF = 2'd0;
  localparam logic [1:0] LED_RED = 2'd1;
  localparam logic [1:0] LED_GRN = 2'd2;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    time_t tick_count;
    logic  button_previous;
    time_t last_press_time;
    logic  fault_latched;
    time_t fault_start_time;
    logic  fault_driving;
    logic  power_state;
    logic  press_ready;
  } state_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ticks;
    logic [CFG_BITS-1:0] flag_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic       power_enable;
    logic [1:0] led_color;
    logic       fault_line_drive;
  } result_t;

endpackage

// ===== design/power_switch_fault_controller_top.sv =====
`timescale 1ns / 1ps
// a poll accepted at one edge shows its result from the next cycle on
// throughput: one poll per cycle; the state update and the result register
// are loaded at the same edge, so in_ready stays high while out_ready is high
// reset (rst, synchronous): state cleared, press_ready set, debounce_ticks 3,
// flag_hold_ticks 2, no result pending

module power_switch_fault_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                tick,
  input  logic                                button_pressed,
  input  logic                                fault_active,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                power_enable,
  output logic [1:0]                          led_color,
  output logic                                fault_line_drive,
  input  logic                                cfg_write,
  input  logic [psfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [psfc_pkg::CFG_BITS-1:0]       cfg_data
);

  psfc_pkg::state_t  state;
  psfc_pkg::state_t  state_next;
  psfc_pkg::cfg_t    cfg;
  psfc_pkg::result_t result;
  logic              in_xfer;

  // result register can be refilled in the cycle it is taken
  assign in_ready = !out_valid || out_ready;
  assign in_xfer = in_valid && in_ready;

  psfc_step u_step (
    .state          (state),
    .cfg            (cfg),
    .tick           (tick),
    .button_pressed (button_pressed),
    .fault_active   (fault_active),
    .state_next     (state_next),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= psfc_pkg::DEBOUNCE_TICKS_RESET;
      cfg.flag_hold_ticks <= psfc_pkg::FLAG_HOLD_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        psfc_pkg::REG_DEBOUNCE_TICKS:  cfg.debounce_ticks <= cfg_data;
        psfc_pkg::REG_FLAG_HOLD_TICKS: cfg.flag_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{press_ready: 1'b1, default: '0};
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        state <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      power_enable <= result.power_enable;
      led_color <= result.led_color;
      fault_line_drive <= result.fault_line_drive;
    end
  end

`ifndef SYNTHESIS
  a_green_when_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && power_enable |-> led_color == psfc_pkg::LED_GRN)
    else $error("power on without green led");

  a_led_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> led_color != 2'd3)
    else $error("led code out of range");

  a_fault_forces_off: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && fault_active |=> out_valid && !power_enable &&
      led_color == psfc_pkg::LED_RED)
    else $error("fault did not force power off");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && state.press_ready)
    else $error("reset left a result pending");
`endif

endmodule

// ===== design/psfc_step.sv =====
`timescale 1ns / 1ps

module psfc_step (
  input  psfc_pkg::state_t  state,
  input  psfc_pkg::cfg_t    cfg,
  input  logic              tick,
  input  logic              button_pressed,
  input  logic              fault_active,
  output psfc_pkg::state_t  state_next,
  output psfc_pkg::result_t result
);

  psfc_pkg::time_t             tc;
  psfc_pkg::time_t             press_elapsed;
  psfc_pkg::time_t             fault_elapsed;
  logic [psfc_pkg::CMP_BITS-1:0] press_cmp;
  logic [psfc_pkg::CMP_BITS-1:0] fault_cmp;
  logic [psfc_pkg::CMP_BITS-1:0] debounce_cmp;
  logic [psfc_pkg::CMP_BITS-1:0] hold_cmp;
  psfc_pkg::state_t            s;

  assign tc = tick ? psfc_pkg::time_t'(state.tick_count + 1'b1) : state.tick_count;
  assign press_elapsed = psfc_pkg::time_t'(tc - state.last_press_time);
  assign press_cmp = psfc_pkg::CMP_BITS'(press_elapsed);
  assign debounce_cmp = psfc_pkg::CMP_BITS'(cfg.debounce_ticks);
  assign hold_cmp = psfc_pkg::CMP_BITS'(cfg.flag_hold_ticks);

  always_comb begin
    s = state;
    s.tick_count = tc;

    if (button_pressed) begin
      if (!state.button_previous && state.press_ready) begin
        s.press_ready = 1'b0;
        if (state.fault_latched) begin
          s.fault_latched = 1'b0;
        end else begin
          s.power_state = !state.power_state;
        end
      end
      s.last_press_time = tc;
    end else if (press_cmp >= debounce_cmp) begin
      s.press_ready = 1'b1;
    end
    s.button_previous = button_pressed;

    if (fault_active) begin
      if (!state.fault_driving) begin
        s.fault_start_time = tc;
      end
      s.fault_latched = 1'b1;
      s.power_state = 1'b0;
      s.fault_driving = 1'b1;
    end
  end

  // hold release looks at the start time chosen in this poll
  assign fault_elapsed = psfc_pkg::time_t'(tc - s.fault_start_time);
  assign fault_cmp = psfc_pkg::CMP_BITS'(fault_elapsed);

  always_comb begin
    state_next = s;
    if (s.fault_latched && s.fault_driving && (fault_cmp >= hold_cmp)) begin
      state_next.fault_driving = 1'b0;
    end
  end

  always_comb begin
    result.power_enable = state_next.power_state;
    result.fault_line_drive = state_next.fault_driving;
    if (state_next.power_state) begin
      result.led_color = psfc_pkg::LED_GRN;
    end else if (state_next.fault_latched) begin
      result.led_color = psfc_pkg::LED_RED;
    end else begin
      result.led_color = psfc_pkg::LED_OFF;
    end
  end

endmodule
